[sv/ftvd_pkg.sv]
package ftvd_pkg;

  localparam int MAX_POSITIONS_DEF = 1048576;
  localparam int TABLE_ENTRIES_DEF = 65536;

  localparam int IDX_W = 24;
  localparam int KEY_W = 2 * IDX_W + 1;
  localparam int CNT_W = IDX_W + 1;
  localparam int RAW_W = 22;

  localparam logic [63:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;

  localparam logic [1:0] ACT_POS    = 2'd0;
  localparam logic [1:0] ACT_UV     = 2'd1;
  localparam logic [1:0] ACT_CORNER = 2'd2;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_RANGE = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             ok;
  } resolved_t;

  function automatic resolved_t resolve(input logic signed [RAW_W-1:0] raw,
                                        input logic [CNT_W-1:0] count);
    logic signed [CNT_W+2:0] r;
    logic signed [CNT_W+2:0] c;
    resolved_t               res;
    c = $signed({3'b000, count});
    if (raw > 0) begin
      r = (CNT_W+3)'(raw) - (CNT_W+3)'(1);
    end else if (raw < 0) begin
      r = c + (CNT_W+3)'(raw);
    end else begin
      r = '1;
    end
    if (r < 0 || r >= c) begin
      res.idx = '0;
      res.ok  = 1'b0;
    end else begin
      res.idx = r[IDX_W-1:0];
      res.ok  = 1'b1;
    end
    return res;
  endfunction

endpackage

[sv/ftvd_mul.sv]
module ftvd_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

[sv/fan_triangulate_vertex_dedup_core.sv]
// Channel  | Ports                                                        | Handshake
// input    | action raw_position_index raw_uv_index uv_given end_of_face  | start && !busy
// result   | vertex_index is_new position_index uv_index uv_present       | strobe, one cycle
//          | error last                                                   |
// Declarations and corners that emit nothing go through the decode state and back to idle.
// A corner that closes a fan triangle emits three words; each is hashed in three passes
// through one 32x32 multiplier, then takes one memory read per probe; a word whose
// corner is out of range skips both.
// After reset the table is swept clear while busy is high.
// Results cannot be stalled; each word shows for exactly one cycle.
// TABLE_ENTRIES must be a power of two.
module fan_triangulate_vertex_dedup_core #(
  parameter int MAX_POSITIONS = ftvd_pkg::MAX_POSITIONS_DEF,
  parameter int TABLE_ENTRIES = ftvd_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic signed [21:0] raw_position_index,
  input  logic signed [21:0] raw_uv_index,
  input  logic        uv_given,
  input  logic        end_of_face,
  output logic        strobe,
  output logic [15:0] vertex_index,
  output logic        is_new,
  output logic [19:0] position_index,
  output logic [19:0] uv_index,
  output logic        uv_present,
  output logic [1:0]  error,
  output logic        last
);

  localparam int CW = $clog2(MAX_POSITIONS + 1);
  localparam int PW = $clog2(MAX_POSITIONS);
  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int KW = ftvd_pkg::KEY_W;
  localparam int EW = 1 + KW + AW;

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_DECODE = 4'd2;
  localparam logic [3:0] ST_EMIT   = 4'd3;
  localparam logic [3:0] ST_H0     = 4'd4;
  localparam logic [3:0] ST_H1     = 4'd5;
  localparam logic [3:0] ST_H2     = 4'd6;
  localparam logic [3:0] ST_H3     = 4'd7;
  localparam logic [3:0] ST_RD     = 4'd8;
  localparam logic [3:0] ST_CMP    = 4'd9;

  function automatic logic [1:0] end_of_face_mux(input logic eof, input logic [1:0] n);
    return eof ? 2'd0 : n;
  endfunction

  logic [3:0]    state;
  logic [AW-1:0] clr_addr;

  logic [1:0]              act_r;
  logic signed [21:0]      rawp_r;
  logic signed [21:0]      rawu_r;
  logic                    uvg_r;
  logic                    eof_r;

  logic [CW-1:0] pcount;
  logic [CW-1:0] ucount;
  logic [1:0]    cif;

  logic [PW-1:0] first_pos, prev_pos, cur_pos;
  logic [PW-1:0] first_uv, prev_uv, cur_uv;
  logic          first_uvok, prev_uvok, cur_uvok;
  logic          first_posok, prev_posok, cur_posok;

  logic [AW:0]   nvn;
  logic [1:0]    e;
  logic [31:0]   acc;
  logic [AW-1:0] slot;
  logic [AW:0]   probes;

  logic [EW-1:0] mem [TABLE_ENTRIES];
  logic [EW-1:0] rd_data;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic [PW-1:0] sel_pos, sel_uv;
  logic          sel_uvok, sel_posok;
  logic [KW-1:0] key;

  ftvd_pkg::resolved_t res_p, res_u;

  logic          res_done, res_new, mem_we;
  logic [AW-1:0] res_vert;
  logic [1:0]    res_err;
  logic [AW:0]   probes_next;
  logic [31:0]   acc_next;

  assign busy = (state != ST_IDLE);

  always_comb begin
    unique case (e)
      2'd0: begin
        sel_pos = first_pos; sel_uv = first_uv;
        sel_uvok = first_uvok; sel_posok = first_posok;
      end
      2'd1: begin
        sel_pos = prev_pos; sel_uv = prev_uv;
        sel_uvok = prev_uvok; sel_posok = prev_posok;
      end
      default: begin
        sel_pos = cur_pos; sel_uv = cur_uv;
        sel_uvok = cur_uvok; sel_posok = cur_posok;
      end
    endcase
    key = {ftvd_pkg::IDX_W'(sel_pos), ftvd_pkg::IDX_W'(sel_uv), sel_uvok};
  end

  always_comb begin
    res_p = ftvd_pkg::resolve(rawp_r, ftvd_pkg::CNT_W'(pcount));
    res_u = ftvd_pkg::resolve(rawu_r, ftvd_pkg::CNT_W'(ucount));
    if (!uvg_r) begin
      res_u = '0;
    end
  end

  always_comb begin
    unique case (state)
      ST_H1: begin
        mul_a = key[31:0];
        mul_b = ftvd_pkg::HASH_MULT[63:32];
      end
      ST_H2: begin
        mul_a = 32'(key[KW-1:32]);
        mul_b = ftvd_pkg::HASH_MULT[31:0];
      end
      default: begin
        mul_a = key[31:0];
        mul_b = ftvd_pkg::HASH_MULT[31:0];
      end
    endcase
  end

  ftvd_mul u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .p  (mul_p)
  );

  assign acc_next    = acc + mul_p[31:0];
  assign probes_next = probes + 1'b1;

  always_comb begin
    res_done = 1'b0;
    res_new  = 1'b0;
    res_vert = '0;
    res_err  = ftvd_pkg::ERR_OK;
    mem_we   = 1'b0;
    if (state == ST_EMIT && !sel_posok) begin
      res_done = 1'b1;
      res_err  = ftvd_pkg::ERR_RANGE;
    end else if (state == ST_CMP) begin
      if (!rd_data[EW-1]) begin
        res_done = 1'b1;
        if (nvn >= (AW+1)'(TABLE_ENTRIES)) begin
          res_err = ftvd_pkg::ERR_FULL;
        end else begin
          mem_we   = 1'b1;
          res_vert = nvn[AW-1:0];
          res_new  = 1'b1;
        end
      end else if (rd_data[EW-2:AW] == key) begin
        res_done = 1'b1;
        res_vert = rd_data[AW-1:0];
      end else if (probes_next == (AW+1)'(TABLE_ENTRIES)) begin
        res_done = 1'b1;
        res_err  = ftvd_pkg::ERR_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      mem[clr_addr] <= '0;
    end else if (mem_we) begin
      mem[slot] <= {1'b1, key, nvn[AW-1:0]};
    end
    rd_data <= mem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      pcount   <= '0;
      ucount   <= '0;
      cif      <= '0;
      nvn      <= '0;
      e        <= '0;
      strobe   <= 1'b0;
      first_pos <= '0; first_uv <= '0; first_uvok <= 1'b0; first_posok <= 1'b0;
      prev_pos  <= '0; prev_uv  <= '0; prev_uvok  <= 1'b0; prev_posok  <= 1'b0;
    end else begin
      strobe <= res_done;
      if (res_done) begin
        vertex_index   <= 16'(res_vert);
        is_new         <= res_new;
        position_index <= 20'(sel_pos);
        uv_index       <= 20'(sel_uv);
        uv_present     <= sel_uvok;
        error          <= res_err;
        last           <= (e == 2'd2);
        if (res_new) begin
          nvn <= nvn + 1'b1;
        end
        if (e == 2'd2) begin
          prev_pos <= cur_pos; prev_uv <= cur_uv;
          prev_uvok <= cur_uvok; prev_posok <= cur_posok;
          cif   <= eof_r ? 2'd0 : 2'd2;
          state <= ST_IDLE;
        end else begin
          e     <= e + 1'b1;
          state <= ST_EMIT;
        end
      end else begin
        unique case (state)
          ST_CLEAR: begin
            clr_addr <= clr_addr + 1'b1;
            if (clr_addr == AW'(TABLE_ENTRIES - 1)) begin
              state <= ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (start) begin
              act_r  <= action;
              rawp_r <= raw_position_index;
              rawu_r <= raw_uv_index;
              uvg_r  <= uv_given;
              eof_r  <= end_of_face;
              state  <= ST_DECODE;
            end
          end
          ST_DECODE: begin
            state <= (act_r == ftvd_pkg::ACT_CORNER && cif == 2'd2) ? ST_EMIT : ST_IDLE;
            unique case (act_r)
              ftvd_pkg::ACT_POS: begin
                if (pcount < CW'(MAX_POSITIONS)) begin
                  pcount <= pcount + 1'b1;
                end
              end
              ftvd_pkg::ACT_UV: begin
                if (ucount < CW'(MAX_POSITIONS)) begin
                  ucount <= ucount + 1'b1;
                end
              end
              ftvd_pkg::ACT_CORNER: begin
                cur_pos   <= PW'(res_p.idx);
                cur_posok <= res_p.ok;
                cur_uv    <= PW'(res_u.idx);
                cur_uvok  <= res_u.ok;
                if (cif == 2'd0) begin
                  first_pos <= PW'(res_p.idx); first_posok <= res_p.ok;
                  first_uv  <= PW'(res_u.idx); first_uvok  <= res_u.ok;
                  cif <= end_of_face_mux(eof_r, 2'd1);
                end else if (cif == 2'd1) begin
                  prev_pos <= PW'(res_p.idx); prev_posok <= res_p.ok;
                  prev_uv  <= PW'(res_u.idx); prev_uvok  <= res_u.ok;
                  cif <= end_of_face_mux(eof_r, 2'd2);
                end else begin
                  e <= 2'd0;
                end
              end
              default: begin
              end
            endcase
          end
          ST_EMIT: state <= ST_H0;
          ST_H0:   state <= ST_H1;
          ST_H1: begin
            acc   <= mul_p[63:32];
            state <= ST_H2;
          end
          ST_H2: begin
            acc   <= acc_next;
            state <= ST_H3;
          end
          ST_H3: begin
            slot   <= acc_next[AW-1:0];
            probes <= '0;
            state  <= ST_RD;
          end
          ST_RD: state <= ST_CMP;
          ST_CMP: begin
            probes <= probes_next;
            slot   <= slot + 1'b1;
            state  <= ST_RD;
          end
          default: state <= ST_IDLE;
        endcase
      end
    end
  end

endmodule

[sv/ftvd_checker.sv]
module ftvd_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        strobe,
  input logic [15:0] vertex_index,
  input logic        is_new,
  input logic [19:0] position_index,
  input logic [19:0] uv_index,
  input logic        uv_present,
  input logic [1:0]  error
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    strobe && error != ftvd_pkg::ERR_OK |-> vertex_index == 16'd0 && !is_new)
    else $error("error word carries a vertex");

  a_range_pos: assert property (@(posedge clk) disable iff (rst)
    strobe && error == ftvd_pkg::ERR_RANGE |-> position_index == 20'd0)
    else $error("out-of-range word carries a position");

  a_uv_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && !uv_present |-> uv_index == 20'd0)
    else $error("uv index without uv");

endmodule

bind fan_triangulate_vertex_dedup_core ftvd_checker u_ftvd_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .strobe        (strobe),
  .vertex_index  (vertex_index),
  .is_new        (is_new),
  .position_index(position_index),
  .uv_index      (uv_index),
  .uv_present    (uv_present),
  .error         (error)
);

[test/fan_triangulate_vertex_dedup_core_test.sv]
module fan_triangulate_vertex_dedup_core_test;

  localparam int MAXP = 32;
  localparam int TE   = 64;

  typedef struct {
    logic [1:0]         act;
    logic signed [21:0] rp;
    logic signed [21:0] ru;
    logic               ug;
    logic               eof;
  } rec_t;

  typedef struct {
    logic [23:0] pos;
    logic [23:0] uv;
    logic        uv_ok;
    logic        pos_ok;
  } corner_t;

  typedef struct {
    logic [15:0] vert;
    logic        isnew;
    logic [19:0] pos;
    logic [19:0] uv;
    logic        uvp;
    logic [1:0]  err;
    logic        lst;
  } word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] action = ftvd_pkg::ACT_POS;
  logic signed [21:0] raw_position_index = '0;
  logic signed [21:0] raw_uv_index = '0;
  logic uv_given = 1'b0;
  logic end_of_face = 1'b0;
  logic busy, strobe, is_new, uv_present, last;
  logic [15:0] vertex_index;
  logic [19:0] position_index, uv_index;
  logic [1:0] error;

  fan_triangulate_vertex_dedup_core #(.MAX_POSITIONS(MAXP), .TABLE_ENTRIES(TE)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .raw_position_index(raw_position_index), .raw_uv_index(raw_uv_index),
    .uv_given(uv_given), .end_of_face(end_of_face), .strobe(strobe),
    .vertex_index(vertex_index), .is_new(is_new), .position_index(position_index),
    .uv_index(uv_index), .uv_present(uv_present), .error(error), .last(last)
  );

  always #2 clk = ~clk;

  rec_t    pending[$];
  word_t   expected_words[$];
  int      mismatches = 0;
  int      pos_count = 0, uv_count = 0, corners = 0, next_vert = 0;
  corner_t first_c, prev_c;
  logic [48:0] tbl_key[TE];
  int      tbl_vert[TE];
  bit      tbl_used[TE];
  bit      accepted = 1'b0;
  int      gap = 0;
  bit      calm = 1'b0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    mismatches++;
  endtask

  function automatic void resolve_idx(input logic signed [21:0] raw, input int cnt,
                                      output logic [23:0] idx, output logic ok);
    longint r;
    if (raw > 0) r = longint'(raw) - 1;
    else if (raw < 0) r = longint'(cnt) + longint'(raw);
    else r = -1;
    ok  = (r >= 0 && r < cnt);
    idx = ok ? r[23:0] : '0;
  endfunction

  task automatic lookup(input corner_t c, input logic lst);
    logic [63:0] key, prod;
    int slot;
    bit done;
    word_t w;
    w = '{default: '0};
    if (!c.pos_ok) begin
      w.err = ftvd_pkg::ERR_RANGE;
    end else begin
      key  = {15'b0, c.pos, c.uv, c.uv_ok};
      prod = key * ftvd_pkg::HASH_MULT;
      slot = prod[63:32] % TE;
      done = 1'b0;
      for (int i = 0; i < TE && !done; i++) begin
        if (!tbl_used[slot]) begin
          if (next_vert >= TE) begin
            w.err = ftvd_pkg::ERR_FULL;
          end else begin
            tbl_used[slot] = 1'b1;
            tbl_key[slot] = key[48:0];
            tbl_vert[slot] = next_vert;
            w.vert = next_vert[15:0];
            w.isnew = 1'b1;
            next_vert++;
          end
          done = 1'b1;
        end else if (tbl_key[slot] == key[48:0]) begin
          w.vert = tbl_vert[slot][15:0];
          done = 1'b1;
        end else begin
          slot = (slot + 1) % TE;
        end
      end
      if (!done) w.err = ftvd_pkg::ERR_FULL;
    end
    w.pos = c.pos_ok ? c.pos[19:0] : '0;
    w.uv  = c.uv_ok ? c.uv[19:0] : '0;
    w.uvp = c.uv_ok;
    w.lst = lst;
    expected_words = {expected_words, w};
  endtask

  task automatic predict_record(input rec_t r);
    corner_t cur;
    if (r.act == ftvd_pkg::ACT_POS) begin
      if (pos_count < MAXP) pos_count++;
    end else if (r.act == ftvd_pkg::ACT_UV) begin
      if (uv_count < MAXP) uv_count++;
    end else if (r.act == ftvd_pkg::ACT_CORNER) begin
      resolve_idx(r.rp, pos_count, cur.pos, cur.pos_ok);
      cur.uv = '0;
      cur.uv_ok = 1'b0;
      if (r.ug) resolve_idx(r.ru, uv_count, cur.uv, cur.uv_ok);
      if (corners == 0) begin
        first_c = cur;
        corners = 1;
      end else if (corners == 1) begin
        prev_c = cur;
        corners = 2;
      end else begin
        lookup(first_c, 1'b0);
        lookup(prev_c, 1'b0);
        lookup(cur, 1'b1);
        prev_c = cur;
      end
      if (r.eof) corners = 0;
    end
  endtask

  always @(posedge clk) begin
    accepted <= !rst && start && !busy;
    if (!rst && start && !busy) predict_record('{action, raw_position_index, raw_uv_index,
                                                 uv_given, end_of_face});
    if (!rst && strobe) begin
      if (expected_words.size() == 0) begin
        report("unexpected word", vertex_index, 0);
      end else begin
        word_t w;
        w = expected_words.pop_front();
        if (vertex_index !== w.vert) report("vertex_index", vertex_index, w.vert);
        if (is_new !== w.isnew) report("is_new", is_new, w.isnew);
        if (position_index !== w.pos) report("position_index", position_index, w.pos);
        if (uv_index !== w.uv) report("uv_index", uv_index, w.uv);
        if (uv_present !== w.uvp) report("uv_present", uv_present, w.uvp);
        if (error !== w.err) report("error", error, w.err);
        if (last !== w.lst) report("last", last, w.lst);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (start && !accepted) begin
      end else if (gap > 0) begin
        start <= 1'b0;
        gap <= gap - 1;
      end else if (pending.size() > 0) begin
        rec_t r;
        r = pending.pop_front();
        start <= 1'b1;
        action <= r.act;
        raw_position_index <= r.rp;
        raw_uv_index <= r.ru;
        uv_given <= r.ug;
        end_of_face <= r.eof;
        if ($urandom_range(0, 29) == 0) calm = !calm;
        gap <= calm ? 0 : $urandom_range(0, 19);
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic void enqueue(input rec_t r);
    pending = {pending, r};
  endfunction

  function automatic void decl(input logic [1:0] a);
    enqueue('{a, '0, '0, 1'b0, 1'b0});
  endfunction

  function automatic void corner(input logic signed [21:0] p, input logic signed [21:0] u,
                                 input logic ug, input logic eof);
    enqueue('{ftvd_pkg::ACT_CORNER, p, u, ug, eof});
  endfunction

  function automatic logic signed [21:0] rand_raw(input int cnt);
    case ($urandom_range(0, 9))
      0: return $signed(22'($urandom));
      1: return 22'sd0;
      2: return -$signed(22'($urandom_range(1, cnt + 2)));
      default: return $signed(22'($urandom_range(1, cnt + 1)));
    endcase
  endfunction

  initial begin
    int n, pc, uc;
    corner(1, 1, 1, 0); corner(1, 1, 1, 0); corner(1, 1, 1, 1);
    decl(ftvd_pkg::ACT_POS); decl(ftvd_pkg::ACT_POS); decl(ftvd_pkg::ACT_UV);
    corner(1, 1, 1, 0); corner(-1, -1, 1, 0); corner(2, 0, 1, 0);
    corner(0, 2, 1, 0); corner(22'sd1048576, -22'sd1048576, 1, 1);
    corner(22'sh1FFFFF, 22'sh200000, 0, 0); corner(2, 5, 0, 1);
    enqueue('{2'd3, 22'sh2AAAAA, 22'sh155555, 1'b1, 1'b1});
    corner(1, 1, 0, 0); decl(ftvd_pkg::ACT_UV); corner(2, -2, 1, 0); corner(-2, 2, 1, 0);
    corner(1, 1, 1, 1);
    pc = 2; uc = 2; n = 0;
    while (n < 180) begin
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1)) begin decl(ftvd_pkg::ACT_POS); pc++; end
        else begin decl(ftvd_pkg::ACT_UV); uc++; end
        n++;
      end else if ($urandom_range(0, 9) == 0) begin
        enqueue('{2'($urandom), 22'($urandom), 22'($urandom), 1'($urandom), 1'($urandom)});
        n++;
      end else begin
        int k;
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++) begin
          corner(rand_raw(pc), rand_raw(uc), $urandom_range(0, 3) != 0, i == k - 1);
          n++;
        end
      end
    end
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
  end

  initial begin
    wait (!rst);
    @(posedge clk);
    wait (pending.size() == 0 && !start && expected_words.size() == 0);
    repeat (1000) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

[sim.f]
sv/ftvd_pkg.sv
sv/ftvd_mul.sv
sv/fan_triangulate_vertex_dedup_core.sv
sv/ftvd_checker.sv
test/fan_triangulate_vertex_dedup_core_test.sv
